// ----- hw/rtl/strb_pkg.sv -----
`default_nettype none

package strb_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned STAMP_W = 16;
	localparam int unsigned CRC_W   = 32;

	localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = 16'hffff;
	localparam logic [STAMP_W-1:0] HALF_WINDOW    = 16'h8000;
	localparam logic [CRC_W-1:0]   CRC_POLY       = 32'hedb88320;

	// Action codes
	localparam logic ACT_SAVE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Classified command passed from front to back
	typedef struct packed {
		logic               action;
		logic [STAMP_W-1:0] stamp;
		logic [DATA_W-1:0]  payload;
		logic [CRC_W-1:0]   crc;
	} cmd_t;

	// One byte of the reflected CRC-32
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

	// b is newer than a within half the stamp space
	function automatic logic stamp_newer(input logic [STAMP_W-1:0] a,
			input logic [STAMP_W-1:0] b);
		logic [STAMP_W-1:0] d;
		d = b - a;
		return (d != '0) && (d < HALF_WINDOW);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/strb_cmd_if.sv -----
`default_nettype none

interface strb_cmd_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [strb_pkg::DATA_W-1:0]    event_payload;
	logic [strb_pkg::CRC_W-1:0]     crc_seed;

	modport source (output valid, output action, output event_payload, output crc_seed,
		input ready);
	modport sink (input valid, input action, input event_payload, input crc_seed,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/strb_rsp_if.sv -----
`default_nettype none

interface strb_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           has_event;
	logic [strb_pkg::STAMP_W-1:0]   event_seq;
	logic [strb_pkg::DATA_W-1:0]    event_data;
	logic [strb_pkg::CRC_W-1:0]     event_crc;

	modport source (output valid, output has_event, output event_seq, output event_data,
		output event_crc, input ready);
	modport sink (input valid, input has_event, input event_seq, input event_data,
		input event_crc, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/strb_front.sv -----
`default_nettype none

module strb_front (
	input  wire           clk,
	input  wire           arst_n,
	strb_cmd_if.sink      cmd,
	output logic          push,
	output strb_pkg::cmd_t push_cmd,
	input  wire           full
);

	logic                          valid_s1;
	logic                          action_s1;
	logic [strb_pkg::STAMP_W-1:0]  stamp_s1;
	logic [strb_pkg::DATA_W-1:0]   payload_s1;
	logic [strb_pkg::CRC_W-1:0]    crc_s1;
	logic [strb_pkg::STAMP_W-1:0]  next_stamp_q;
	logic                          accept;

	// Take a word when stage one is empty or moving on
	assign cmd.ready = !valid_s1 || !full;
	assign accept    = cmd.valid && cmd.ready;
	assign push      = valid_s1 && !full;

	// Finish the CRC over the low stamp byte on the way into the queue
	always_comb begin
		push_cmd.action  = action_s1;
		push_cmd.stamp   = stamp_s1;
		push_cmd.payload = payload_s1;
		push_cmd.crc     = ~strb_pkg::crc_byte(crc_s1, stamp_s1[7:0]);
	end

	// Stage-one control and stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			next_stamp_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (cmd.action == strb_pkg::ACT_SAVE) next_stamp_q <= next_stamp_q + 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage-one payload: stamp the word and run the CRC over the high byte
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= cmd.action;
			stamp_s1   <= next_stamp_q;
			payload_s1 <= cmd.event_payload;
			crc_s1     <= strb_pkg::crc_byte(~cmd.crc_seed, next_stamp_q[15:8]);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/strb_queue.sv -----
`default_nettype none

module strb_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  strb_pkg::cmd_t push_cmd,
	output logic           full,
	input  wire            pop,
	output logic           valid,
	output strb_pkg::cmd_t head
);

	strb_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/strb_back.sv -----
`default_nettype none

module strb_back #(
	parameter int unsigned SLOTS        = 64,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            q_valid,
	input  strb_pkg::cmd_t q_head,
	output logic           q_pop,
	strb_rsp_if.source     rsp
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned FW = $clog2(SLOTS + 1);
	localparam logic [AW-1:0] LAST_POS  = AW'(SLOTS - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(SLOTS);

	typedef enum logic {ST_IDLE, ST_CHECK} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 rd_pos_q;
	logic [AW-1:0]                 wr_pos_q;
	logic [FW-1:0]                 fill_q;
	logic [strb_pkg::STAMP_W-1:0]  last_q;
	logic                          written_s1;

	logic [strb_pkg::STAMP_W-1:0]  stamp_mem [SLOTS];
	logic [PAYLOAD_BITS-1:0]       payload_mem [SLOTS];
	logic [strb_pkg::CRC_W-1:0]    check_mem [SLOTS];
	logic [strb_pkg::STAMP_W-1:0]  stamp_rd_s1;
	logic [PAYLOAD_BITS-1:0]       payload_rd_s1;
	logic [strb_pkg::CRC_W-1:0]    check_rd_s1;

	logic                          out_valid_q;
	logic                          out_has_q;
	logic [strb_pkg::STAMP_W-1:0]  out_seq_q;
	logic [strb_pkg::DATA_W-1:0]   out_data_q;
	logic [strb_pkg::CRC_W-1:0]    out_crc_q;

	logic                          do_save;
	logic                          do_read;
	logic                          out_free;
	logic                          load;
	logic                          newer;
	logic [strb_pkg::STAMP_W-1:0]  stamp_chk;
	logic [strb_pkg::DATA_W-1:0]   data_ext;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign do_save  = q_pop && (q_head.action == strb_pkg::ACT_SAVE);
	assign do_read  = q_pop && (q_head.action == strb_pkg::ACT_READ);
	assign out_free = !out_valid_q || rsp.ready;
	assign load     = (state_q == ST_CHECK) && out_free;

	// Unwritten slots keep their reset stamp
	always_comb begin
		if (written_s1) stamp_chk = stamp_rd_s1;
		else if (rd_pos_q == '0) stamp_chk = strb_pkg::STAMP_ALL_ONES;
		else stamp_chk = '0;
		newer = strb_pkg::stamp_newer(last_q, stamp_chk);
		data_ext = '0;
		data_ext[PAYLOAD_BITS-1:0] = payload_rd_s1;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.has_event  = out_has_q;
	assign rsp.event_seq  = out_seq_q;
	assign rsp.event_data = out_data_q;
	assign rsp.event_crc  = out_crc_q;

	// Slot memories: write on save, registered read on read
	always_ff @(posedge clk) begin
		if (do_save) begin
			stamp_mem[wr_pos_q]   <= q_head.stamp;
			payload_mem[wr_pos_q] <= q_head.payload[PAYLOAD_BITS-1:0];
			check_mem[wr_pos_q]   <= q_head.crc;
		end
		if (do_read) begin
			stamp_rd_s1   <= stamp_mem[rd_pos_q];
			payload_rd_s1 <= payload_mem[rd_pos_q];
			check_rd_s1   <= check_mem[rd_pos_q];
		end
	end

	// Sequencer, positions and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_pos_q    <= '0;
			wr_pos_q    <= '0;
			fill_q      <= '0;
			last_q      <= strb_pkg::STAMP_ALL_ONES;
			written_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			out_has_q   <= 1'b0;
			out_seq_q   <= '0;
			out_data_q  <= '0;
			out_crc_q   <= '0;
		end else begin
			if (out_valid_q && rsp.ready && !load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (do_save) begin
						wr_pos_q <= (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + 1'b1;
						if (fill_q != FILL_FULL) fill_q <= fill_q + 1'b1;
					end
					if (do_read) begin
						written_s1 <= (fill_q > FW'(rd_pos_q));
						state_q    <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_has_q   <= newer;
						if (newer) begin
							out_seq_q  <= stamp_chk;
							out_data_q <= data_ext;
							out_crc_q  <= check_rd_s1;
							last_q     <= stamp_chk;
							rd_pos_q   <= (rd_pos_q == LAST_POS) ? '0 : rd_pos_q + 1'b1;
						end else begin
							out_seq_q  <= '0;
							out_data_q <= '0;
							out_crc_q  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond slot count");

	a_no_pop_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> !q_pop)
		else $error("queue popped while a read is in progress");

	a_last_follows_send: assert property (@(posedge clk) disable iff (!arst_n)
		(load && newer) |=> (last_q == $past(stamp_chk)) && out_has_q)
		else $error("last sent stamp not updated on send");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_has_q) |->
			(out_seq_q == '0) && (out_data_q == '0) && (out_crc_q == '0))
		else $error("empty result carries data");

	a_empty_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !newer) |=> $stable(rd_pos_q) && $stable(last_q))
		else $error("empty read moved the read position");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sequenced_trace_ring_buffer_top.sv -----
`default_nettype none

// Channel  Role    Word
// cmd      sink    action, event_payload, crc_seed
// rsp      source  has_event, event_seq, event_data, event_crc (one per read)
//
// A save is written to the slot memories as it leaves the queue; a read goes
// through the slot memory read, then compare and load of the output register.
// A word passes the front stage register and the queue before the back end.
// Sustained rate: 1 save per cycle while no read holds the back end; a read holds
// it until its result is loaded, as the slot memory read is registered.
// Reset clears positions, the stamp counter and the fill count and sets the last
// sent stamp to all ones; the fill count stands in for the reset stamps, so no clearing pass.
// A 2-entry queue parts front and back; a stalled rsp holds the back end at the
// next read, and words queued behind that read wait with it.

module sequenced_trace_ring_buffer_top #(
	parameter int unsigned SLOTS        = 64,
	parameter int unsigned PAYLOAD_BITS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	strb_cmd_if.sink   cmd,
	strb_rsp_if.source rsp
);

	logic           push;
	strb_pkg::cmd_t push_cmd;
	logic           full;
	logic           pop;
	logic           q_valid;
	strb_pkg::cmd_t q_head;

	strb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	strb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	strb_back #(
		.SLOTS        (SLOTS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
